/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// Clocked assertion on the block clock and reset.
`define ASSERT_BLK(label, prop, msg) \
	`ASSERT_ON_CLK(label, clk, arst_n, prop, msg)

`endif

/* design/mtg_pkg.sv */
package mtg_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int IDX_W         = $clog2(STATE_WORDS);

	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] TWIST_COEF   = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic load_seed;
		logic use_default;
		logic seed_step;
		logic rd_issue;
		logic twist;
	} mtg_cmd_t;

	typedef struct packed {
		logic seed_done;
	} mtg_sts_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* design/mtg_dp.sv */
module mtg_dp
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mtg_cmd_t    cmd,
	input  logic [31:0] seed_value,
	output mtg_sts_t    sts,
	output logic [31:0] random_word
);

	logic [31:0] word_q [STATE_WORDS];

	idx_t        idx_q;
	idx_t        k_q;
	logic [31:0] prev_q;
	logic [31:0] cur_q;
	logic [31:0] rda_q;
	logic [31:0] rdb_q;
	logic [31:0] rword_q;

	logic [31:0] seed_in;
	logic [31:0] mix;
	logic [31:0] prod_lo;
	logic [31:0] seed_next;
	idx_t        nxt_idx;
	logic [IDX_W:0] far_sum;
	idx_t        far_idx;
	logic [31:0] y;
	logic [31:0] twisted;

	assign seed_in   = cmd.use_default ? DEFAULT_SEED : seed_value;
	assign mix       = prev_q ^ (prev_q >> 30);
	assign prod_lo   = mix * INIT_MULT;
	assign seed_next = prod_lo + 32'(k_q);

	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_sum = {1'b0, idx_q} + (IDX_W + 1)'(MIDDLE_OFFSET);
	assign far_idx = (far_sum >= (IDX_W + 1)'(STATE_WORDS))
		? IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];

	assign y       = {cur_q[31], rda_q[30:0]};
	assign twisted = rdb_q ^ (y >> 1) ^ (y[0] ? TWIST_COEF : 32'd0);

	assign sts.seed_done = (k_q == LAST_IDX);
	assign random_word   = rword_q;

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			word_q[0] <= seed_in;
		end else if (cmd.seed_step) begin
			word_q[k_q] <= seed_next;
		end else if (cmd.twist) begin
			word_q[idx_q] <= twisted;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rda_q <= word_q[nxt_idx];
			rdb_q <= word_q[far_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.load_seed) begin
				idx_q <= '0;
				k_q   <= idx_t'(1);
			end else if (cmd.seed_step) begin
				k_q <= k_q + 1'b1;
			end else if (cmd.twist) begin
				idx_q <= nxt_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			prev_q <= seed_in;
			cur_q  <= seed_in;
		end else if (cmd.seed_step) begin
			prev_q <= seed_next;
		end else if (cmd.twist) begin
			cur_q   <= rda_q;
			rword_q <= temper(twisted);
		end
	end

endmodule

/* design/mtg_ctrl.sv */
module mtg_ctrl
	import mtg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     kind,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  mtg_sts_t sts,
	output mtg_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SEED  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_TWIST = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       seeded_q;
	logic       pend_q;
	logic       out_valid_q;
	logic       in_xfer;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (kind) begin
						cmd.load_seed = 1'b1;
						state_d       = ST_SEED;
					end else if (!seeded_q) begin
						cmd.load_seed   = 1'b1;
						cmd.use_default = 1'b1;
						state_d         = ST_SEED;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
				if (sts.seed_done) begin
					state_d = pend_q ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_TWIST;
			end
			ST_TWIST: begin
				if (out_free) begin
					cmd.twist = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_seed) begin
				seeded_q <= 1'b1;
				pend_q   <= cmd.use_default;
			end
			if (cmd.twist) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/mersenne_twister_generator.sv */
// MT19937 generator with one input channel and one result channel.
// Input: in_valid/in_stall carry kind and seed_value. kind 1 reseeds the
// 624-word store from seed_value and gives no result; kind 0 asks for one
// tempered 32-bit word, which leaves on out_valid/out_stall as random_word.
// Each word of the store is twisted in place just before it is read, so
// a next request passes through a read step and then a twist step.
// in_stall stays high until a request is finished, so a new request is
// not taken while the last one is in work. Reseeding writes one word per
// cycle through the initialization multiplier and holds in_stall until
// the store is filled. The first next request after reset seeds with
// 5489 first, and only then reads and twists its word.
// Reset clears the controller: no result pending, store marked never seeded.
// The store itself is not cleared; it is always seeded before it is read.
// While out_stall holds a waiting word, the block keeps its next result in
// the twist step and holds in_stall high; the waiting word stays unchanged.
module mersenne_twister_generator
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word
);

	mtg_cmd_t cmd;
	mtg_sts_t sts;

	mtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mtg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.sts         (sts),
		.random_word (random_word)
	);

endmodule

/* design/mtg_checker.sv */
`include "assert_macros.svh"

module mtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic [31:0] seed_value,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] random_word
);

	`ASSERT_BLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(random_word)), "stalled result changed")
	`ASSERT_BLK(a_in_hold, (in_valid && in_stall) |=> (in_valid && $stable({kind, seed_value})), "stalled input changed")
	`ASSERT_BLK(a_seed_busy, (in_valid && !in_stall && kind) |=> in_stall, "seed transfer did not start a fill")
	`ASSERT_BLK(a_next_busy, (in_valid && !in_stall && !kind) |=> (in_stall && !$rose(out_valid)), "next transfer answered too early")
	`ASSERT_BLK(a_out_after_work, $rose(out_valid) |-> $past(in_stall), "result appeared without work")

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
